// File: rtl/graph_bfs_dfs_traversal_macros.svh
// ----------------------------------------------------------------------------
// Graph traversal assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal package
// Sizes, action and status codes, and the records shared by the modules.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VTX_W  = 6;                          // vertex field width
  localparam int CNT_W  = 7;                          // vertex_count width
  localparam int VIDX_W = $clog2(MAX_VERTICES);       // index into vertex maps
  localparam int PTR_W  = $clog2(MAX_VERTICES + 1);   // queue / stack pointer
  localparam int EA_W   = $clog2(MAX_EDGES);          // edge store address
  localparam int EC_W   = $clog2(MAX_EDGES + 1);      // edge count

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_BFS  = 2'd1;
  localparam logic [1:0] ACT_DFS  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CNT_W-1:0] VCOUNT_RST = CNT_W'(MAX_VERTICES);

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    logic             push;
    logic             fin;
    logic [VTX_W-1:0] vertex;
    logic [1:0]       status;
  } gbt_emit_t;

  // One row of the list memory: first and last edge of a vertex.
  typedef struct packed {
    logic [EA_W-1:0] head;
    logic [EA_W-1:0] tail;
  } gbt_list_t;

  // One entry of the work store: queue slot or stack frame.
  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic [EA_W-1:0]  eptr;
    logic             live;
  } gbt_frame_t;

endpackage

// File: rtl/graph_bfs_dfs_traversal.sv
// An add-edge item or an error item shows one result, and the input is held
// off until an item is done, so a new item is not taken while one is in progress.
// A traversal's pace is set by the one read port of the edge and list memories.
// Reset restores vertex_count to 64, empties all lists, ready.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal top level
// Directed graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal
  import gbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [VTX_W-1:0] src_vertex_i,
  input  logic [VTX_W-1:0] dest_vertex_i,
  input  logic [VTX_W-1:0] start_vertex_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VTX_W-1:0] vertex_o,
  output logic             last_o,
  output logic [1:0]       status_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  gbt_emit_t emit;
  logic      rdy;

  gbt_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .src_vertex_i   (src_vertex_i),
    .dest_vertex_i  (dest_vertex_i),
    .start_vertex_i (start_vertex_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .emit_o         (emit),
    .rdy_i          (rdy)
  );

  gbt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .rdy_o       (rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_o    (vertex_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

// File: rtl/gbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gbt_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal output stage
// Holds one pending result until the next one or the end of the item is
// known, so the final result can carry last, then registers the output.
// ----------------------------------------------------------------------------
module gbt_out_stage
  import gbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbt_emit_t        emit_i,
  output logic             rdy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VTX_W-1:0] vertex_o,
  output logic             last_o,
  output logic [1:0]       status_o
);

  logic             pend_v_q, pend_v_d;
  logic [VTX_W-1:0] pend_vtx_q, pend_vtx_d;
  logic [1:0]       pend_st_q, pend_st_d;
  logic             out_v_q, out_v_d;
  logic [VTX_W-1:0] out_vtx_q, out_vtx_d;
  logic             out_last_q, out_last_d;
  logic [1:0]       out_st_q, out_st_d;
  logic             rdy;
  logic             move;

  always_comb begin
    rdy        = !pend_v_q || !out_v_q || !out_stall_i;
    move       = rdy && pend_v_q && (emit_i.push || emit_i.fin);
    out_v_d    = out_v_q && out_stall_i;
    out_vtx_d  = out_vtx_q;
    out_last_d = out_last_q;
    out_st_d   = out_st_q;
    pend_v_d   = pend_v_q;
    pend_vtx_d = pend_vtx_q;
    pend_st_d  = pend_st_q;
    // advance pending result to the output register
    if (move) begin
      out_v_d    = 1'b1;
      out_vtx_d  = pend_vtx_q;
      out_st_d   = pend_st_q;
      out_last_d = emit_i.fin;
    end
    if (emit_i.push && rdy) begin
      pend_v_d   = 1'b1;
      pend_vtx_d = emit_i.vertex;
      pend_st_d  = emit_i.status;
    end else if (emit_i.fin && rdy) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vtx_q <= pend_vtx_d;
    pend_st_q  <= pend_st_d;
    out_vtx_q  <= out_vtx_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
  end

  assign rdy_o       = rdy;
  assign out_valid_o = out_v_q;
  assign vertex_o    = out_vtx_q;
  assign last_o      = out_last_q;
  assign status_o    = out_st_q;

endmodule

// File: rtl/gbt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal sequencer
// Owns the edge, list and work memories and steps one edge or one vertex
// per visit through them for add-edge, breadth-first and depth-first items.
// ----------------------------------------------------------------------------
module gbt_seq
  import gbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [VTX_W-1:0] src_vertex_i,
  input  logic [VTX_W-1:0] dest_vertex_i,
  input  logic [VTX_W-1:0] start_vertex_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output gbt_emit_t        emit_o,
  input  logic             rdy_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ADDW  = 4'd2;
  localparam logic [3:0] S_RES1  = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_BPOP  = 4'd5;
  localparam logic [3:0] S_BPOPW = 4'd6;
  localparam logic [3:0] S_BLIST = 4'd7;
  localparam logic [3:0] S_BEDGE = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DTOP  = 4'd10;
  localparam logic [3:0] S_DEDGE = 4'd11;
  localparam logic [3:0] S_DNEWL = 4'd12;
  localparam logic [3:0] S_DPOPW = 4'd13;
  localparam logic [3:0] S_DPOPL = 4'd14;

  localparam int FRAME_W = $bits(gbt_frame_t);
  localparam int LIST_W  = $bits(gbt_list_t);

  logic [3:0]             state_q, state_d;
  logic [1:0]             act_q, act_d;
  logic [VTX_W-1:0]       src_q, src_d;
  logic [VTX_W-1:0]       dst_q, dst_d;
  logic [VTX_W-1:0]       start_q, start_d;
  logic [1:0]             st_q, st_d;
  logic [CNT_W-1:0]       vcount_q;
  logic [EC_W-1:0]        ec_q, ec_d;
  logic [MAX_VERTICES-1:0] nonempty_q, nonempty_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [PTR_W-1:0]       rd_q, rd_d;
  logic [VTX_W-1:0]       top_v_q, top_v_d;
  logic [EA_W-1:0]        top_e_q, top_e_d;
  logic [EA_W-1:0]        top_tail_q, top_tail_d;
  logic                   top_live_q, top_live_d;

  logic                   dest_we;
  logic [EA_W-1:0]        dest_waddr;
  logic [VTX_W-1:0]       dest_wdata;
  logic [VTX_W-1:0]       dest_rdata;
  logic                   next_we;
  logic [EA_W-1:0]        next_waddr;
  logic [EA_W-1:0]        next_wdata;
  logic [EA_W-1:0]        next_rdata;
  logic                   edge_re;
  logic [EA_W-1:0]        edge_raddr;
  logic                   list_we;
  logic [VIDX_W-1:0]      list_waddr;
  gbt_list_t              list_wdata;
  logic                   list_re;
  logic [VIDX_W-1:0]      list_raddr;
  logic [LIST_W-1:0]      list_rdata;
  logic                   ws_we;
  logic [VIDX_W-1:0]      ws_waddr;
  gbt_frame_t             ws_wdata;
  logic                   ws_re;
  logic [VIDX_W-1:0]      ws_raddr;
  logic [FRAME_W-1:0]     ws_rdata;

  gbt_list_t              list_rd;
  gbt_frame_t             ws_rd;
  logic [CNT_W-1:0]       count;
  logic                   d_ok;
  logic                   e_last;
  logic                   ptr_room;
  logic                   ec_full;
  logic [VIDX_W-1:0]      dest_idx;

  assign list_rd  = gbt_list_t'(list_rdata);
  assign ws_rd    = gbt_frame_t'(ws_rdata);
  assign count    = (vcount_q > VCOUNT_RST) ? VCOUNT_RST : vcount_q;
  assign dest_idx = dest_rdata[VIDX_W-1:0];
  assign d_ok     = ({1'b0, dest_rdata} < count) && !visited_q[dest_idx];
  assign e_last   = (top_e_q == top_tail_q);
  assign ptr_room = (ptr_q < PTR_W'(MAX_VERTICES));
  assign ec_full  = (ec_q >= EC_W'(MAX_EDGES));

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    src_d      = src_q;
    dst_d      = dst_q;
    start_d    = start_q;
    st_d       = st_q;
    ec_d       = ec_q;
    nonempty_d = nonempty_q;
    visited_d  = visited_q;
    ptr_d      = ptr_q;
    rd_d       = rd_q;
    top_v_d    = top_v_q;
    top_e_d    = top_e_q;
    top_tail_d = top_tail_q;
    top_live_d = top_live_q;

    emit_o     = '0;
    dest_we    = 1'b0;
    dest_waddr = ec_q[EA_W-1:0];
    dest_wdata = dst_q;
    next_we    = 1'b0;
    next_waddr = list_rd.tail;
    next_wdata = ec_q[EA_W-1:0];
    edge_re    = 1'b0;
    edge_raddr = top_e_q;
    list_we    = 1'b0;
    list_waddr = src_q[VIDX_W-1:0];
    list_wdata = '0;
    list_re    = 1'b0;
    list_raddr = src_q[VIDX_W-1:0];
    ws_we      = 1'b0;
    ws_waddr   = ptr_q[VIDX_W-1:0];
    ws_wdata   = '0;
    ws_re      = 1'b0;
    ws_raddr   = rd_q[VIDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          src_d   = src_vertex_i;
          dst_d   = dest_vertex_i;
          start_d = start_vertex_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        unique case (act_q)
          ACT_ADD: begin
            if (({1'b0, src_q} >= count) || ({1'b0, dst_q} >= count)) begin
              st_d    = ST_RANGE;
              state_d = S_RES1;
            end else if (ec_full) begin
              st_d    = ST_FULL;
              state_d = S_RES1;
            end else begin
              list_re = 1'b1;
              state_d = S_ADDW;
            end
          end
          ACT_BFS, ACT_DFS: begin
            if ({1'b0, start_q} >= count) begin
              st_d    = ST_RANGE;
              state_d = S_RES1;
            end else begin
              visited_d = '0;
              visited_d[start_q[VIDX_W-1:0]] = 1'b1;
              if (act_q == ACT_BFS) begin
                ws_we        = 1'b1;
                ws_waddr     = '0;
                ws_wdata.vtx = start_q;
                ptr_d        = PTR_W'(1);
                rd_d         = '0;
                state_d      = S_BPOP;
              end else begin
                list_re    = 1'b1;
                list_raddr = start_q[VIDX_W-1:0];
                state_d    = S_DINIT;
              end
            end
          end
          default: begin
            // unused action: drop silently
            state_d = S_IDLE;
          end
        endcase
      end

      S_ADDW: begin
        dest_we    = 1'b1;
        next_we    = nonempty_q[src_q[VIDX_W-1:0]];
        list_we    = 1'b1;
        list_wdata.head = nonempty_q[src_q[VIDX_W-1:0]] ? list_rd.head : ec_q[EA_W-1:0];
        list_wdata.tail = ec_q[EA_W-1:0];
        nonempty_d[src_q[VIDX_W-1:0]] = 1'b1;
        ec_d       = ec_q + EC_W'(1);
        st_d       = ST_OK;
        state_d    = S_RES1;
      end

      S_RES1: begin
        if (rdy_i) begin
          emit_o.push   = 1'b1;
          emit_o.status = st_q;
          state_d       = S_FIN;
        end
      end

      S_FIN: begin
        if (rdy_i) begin
          emit_o.fin = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // breadth-first: queue in the work store, rd_q chases ptr_q
      S_BPOP: begin
        if (rd_q == ptr_q) begin
          state_d = S_FIN;
        end else begin
          ws_re   = 1'b1;
          rd_d    = rd_q + PTR_W'(1);
          state_d = S_BPOPW;
        end
      end

      S_BPOPW: begin
        if (rdy_i) begin
          emit_o.push   = 1'b1;
          emit_o.vertex = ws_rd.vtx;
          emit_o.status = ST_OK;
          if (nonempty_q[ws_rd.vtx[VIDX_W-1:0]]) begin
            list_re    = 1'b1;
            list_raddr = ws_rd.vtx[VIDX_W-1:0];
            state_d    = S_BLIST;
          end else begin
            state_d = S_BPOP;
          end
        end
      end

      S_BLIST: begin
        top_e_d    = list_rd.head;
        top_tail_d = list_rd.tail;
        edge_re    = 1'b1;
        edge_raddr = list_rd.head;
        state_d    = S_BEDGE;
      end

      S_BEDGE: begin
        if (d_ok && ptr_room) begin
          visited_d[dest_idx] = 1'b1;
          ws_we        = 1'b1;
          ws_wdata.vtx = dest_rdata;
          ptr_d        = ptr_q + PTR_W'(1);
        end
        if (e_last) begin
          state_d = S_BPOP;
        end else begin
          top_e_d    = next_rdata;
          edge_re    = 1'b1;
          edge_raddr = next_rdata;
        end
      end

      // depth-first: top frame lives in registers, frames below in the store
      S_DINIT: begin
        if (rdy_i) begin
          emit_o.push   = 1'b1;
          emit_o.vertex = start_q;
          emit_o.status = ST_OK;
          top_v_d       = start_q;
          top_e_d       = list_rd.head;
          top_tail_d    = list_rd.tail;
          top_live_d    = nonempty_q[start_q[VIDX_W-1:0]];
          ptr_d         = PTR_W'(1);
          state_d       = S_DTOP;
        end
      end

      S_DTOP: begin
        if (top_live_q) begin
          edge_re = 1'b1;
          state_d = S_DEDGE;
        end else if (ptr_q == PTR_W'(1)) begin
          state_d = S_FIN;
        end else begin
          ptr_d    = ptr_q - PTR_W'(1);
          ws_re    = 1'b1;
          ws_raddr = VIDX_W'(ptr_q - PTR_W'(2));
          state_d  = S_DPOPW;
        end
      end

      S_DEDGE: begin
        if (d_ok && ptr_room) begin
          // descend: wait for room in the output stage
          if (rdy_i) begin
            emit_o.push   = 1'b1;
            emit_o.vertex = dest_rdata;
            emit_o.status = ST_OK;
            visited_d[dest_idx] = 1'b1;
            ws_we         = 1'b1;
            ws_waddr      = VIDX_W'(ptr_q - PTR_W'(1));
            ws_wdata.vtx  = top_v_q;
            ws_wdata.eptr = e_last ? top_e_q : next_rdata;
            ws_wdata.live = !e_last;
            ptr_d         = ptr_q + PTR_W'(1);
            top_v_d       = dest_rdata;
            top_live_d    = nonempty_q[dest_idx];
            list_re       = 1'b1;
            list_raddr    = dest_idx;
            state_d       = S_DNEWL;
          end
        end else begin
          if (e_last) begin
            top_live_d = 1'b0;
          end else begin
            top_e_d = next_rdata;
          end
          state_d = S_DTOP;
        end
      end

      S_DNEWL: begin
        top_e_d    = list_rd.head;
        top_tail_d = list_rd.tail;
        state_d    = S_DTOP;
      end

      S_DPOPW: begin
        top_v_d    = ws_rd.vtx;
        top_e_d    = ws_rd.eptr;
        top_live_d = ws_rd.live;
        list_re    = 1'b1;
        list_raddr = ws_rd.vtx[VIDX_W-1:0];
        state_d    = S_DPOPL;
      end

      S_DPOPL: begin
        top_tail_d = list_rd.tail;
        state_d    = S_DTOP;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vcount_q   <= VCOUNT_RST;
      ec_q       <= '0;
      nonempty_q <= '0;
      visited_q  <= '0;
      ptr_q      <= '0;
      rd_q       <= '0;
      top_live_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      ec_q       <= ec_d;
      nonempty_q <= nonempty_d;
      visited_q  <= visited_d;
      ptr_q      <= ptr_d;
      rd_q       <= rd_d;
      top_live_q <= top_live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    start_q    <= start_d;
    st_q       <= st_d;
    top_v_q    <= top_v_d;
    top_e_q    <= top_e_d;
    top_tail_q <= top_tail_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  gbt_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_dest_ram (
    .clk_i   (clk_i),
    .we_i    (dest_we),
    .waddr_i (dest_waddr),
    .wdata_i (dest_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (dest_rdata)
  );

  gbt_ram #(.WIDTH(EA_W), .DEPTH(MAX_EDGES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (next_rdata)
  );

  gbt_ram #(.WIDTH(LIST_W), .DEPTH(MAX_VERTICES)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  gbt_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_VERTICES)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (ws_we),
    .waddr_i (ws_waddr),
    .wdata_i (ws_wdata),
    .re_i    (ws_re),
    .raddr_i (ws_raddr),
    .rdata_o (ws_rdata)
  );

endmodule

// File: rtl/gbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal checker
// Port-level assertions on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_bfs_dfs_traversal_macros.svh"

module gbt_checker
  import gbt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [VTX_W-1:0] vertex_o,
  input logic             last_o,
  input logic [1:0]       status_o
);

  logic             in_acc;
  logic             out_held;
  logic             err_out;
  logic [VTX_W+2:0] out_bus;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign err_out  = out_valid_o && (status_o != ST_OK);
  assign out_bus  = {vertex_o, last_o, status_o};

  `GBT_ASSERT_NEXT(a_in_busy, in_acc, in_stall_o, "accepted input not held off")
  `GBT_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "result dropped while stalled")
  `GBT_ASSERT_NEXT(a_out_stable, out_held, $stable(out_bus), "stalled result changed")
  `GBT_ASSERT_NOW(a_err_single, err_out, last_o && (vertex_o == '0), "bad error result")
  `GBT_ASSERT_NOW(a_status_code, out_valid_o, status_o <= ST_RANGE, "reserved status code")

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (.*);
